// File: rtl/core/unsorted_table_search_insert_delete_top_assert.svh
// Assertion macros used by the unsorted table datapath.
// Each macro checks a property on the rising edge of clock, quiet while reset is high.
`ifndef UNSORTED_TABLE_SEARCH_INSERT_DELETE_TOP_ASSERT_SVH
`define UNSORTED_TABLE_SEARCH_INSERT_DELETE_TOP_ASSERT_SVH

// Plain property check.
`define UTSID_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Overlapping implication check.
`define UTSID_ASSERT_IMPL(lbl, ante, cons, msg) \
   `UTSID_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication check.
`define UTSID_ASSERT_NEXT(lbl, ante, cons, msg) \
   `UTSID_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: rtl/core/utsid_pkg.sv
// Types and codes shared by the unsorted table controller, datapath and top level.
// Depends on nothing.
package utsid_pkg;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_RSVD   = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_DEL_SHIFT,
      S_INS_SHIFT,
      S_INS_WRITE
   } state_type;

   // Walk pointer updates.
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_ZERO,
      PTR_TOP,
      PTR_AFTER_HIT,
      PTR_INC,
      PTR_DEC
   } ptr_op_type;

   // Table write selection.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_UP,
      WR_DOWN,
      WR_KEY
   } wr_op_type;

   // Fill count updates.
   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   // Source of the reported index.
   typedef enum logic [1:0] {
      IDX_ZERO,
      IDX_RDQ,
      IDX_SAVED
   } idx_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      ptr_op_type  ptr_op;
      logic        rd;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      logic        save_idx;
      logic        respond;
      status_type  rsp_status;
      idx_sel_type idx_sel;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type func;
      logic   empty;
      logic   full;
      logic   pos_bad;
      logic   append;
      logic   rd_vld;
      logic   hit;
      logic   last_up;
      logic   last_ins;
   } flags_type;

endpackage

// File: rtl/core/utsid_dpath.sv
// Datapath of the unsorted table: entry memory, fill count, walk pointer and response registers.
// Depends on utsid_pkg and the assertion macro header.
`include "unsorted_table_search_insert_delete_top_assert.svh"

module utsid_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  utsid_pkg::cmd_type    cmd,
   output utsid_pkg::flags_type  flags,
   input  logic [1:0]            req_func,
   input  logic signed [31:0]    req_key,
   input  logic [4:0]            req_position,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [3:0]            rsp_found_index,
   output logic [4:0]            rsp_length_after
);
   import utsid_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

   // Captured request.
   op_type             func_ff;
   logic signed [31:0] key_ff;
   logic [4:0]         pos_ff;

   // Table state and walk state.
   logic signed [31:0] entries_ff [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [IDX_W-1:0]   rdq_ff;
   logic               rd_vld_ff;
   logic signed [31:0] rd_data_ff;
   logic [IDX_W-1:0]   idx_ff;

   // Response registers.
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]   rsp_len_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic signed [31:0] wr_data;
   logic [IDX_W-1:0]   pos_idx;
   logic [CNT_W-1:0]   rdq_next;
   logic [CMP_W-1:0]   pos_cmp, cnt_cmp;

   // Common index and compare values.
   assign pos_idx  = IDX_W'(pos_ff - 5'd1);
   assign rdq_next = CNT_W'(rdq_ff) + CNT_W'(1);
   assign pos_cmp  = CMP_W'(pos_ff);
   assign cnt_cmp  = CMP_W'(count_ff);

   // Status toward the controller.
   always_comb begin
      flags.func     = func_ff;
      flags.empty    = (count_ff == '0);
      flags.full     = (count_ff == CNT_W'(DEPTH));
      flags.pos_bad  = (pos_ff == 5'd0) || (pos_cmp > cnt_cmp + CMP_W'(1));
      flags.append   = (pos_cmp == cnt_cmp + CMP_W'(1));
      flags.rd_vld   = rd_vld_ff;
      flags.hit      = rd_vld_ff && (rd_data_ff == key_ff);
      flags.last_up  = (rdq_next == count_ff);
      flags.last_ins = (CMP_W'(rdq_ff) == pos_cmp - CMP_W'(1));
   end

   // Reads are only issued for valid entries.
   assign rd_en   = cmd.rd && (ptr_ff < count_ff);
   assign rd_addr = ptr_ff[IDX_W-1:0];

   // Walk pointer update.
   always_comb begin
      case (cmd.ptr_op)
         PTR_ZERO:      ptr_in = '0;
         PTR_TOP:       ptr_in = count_ff - CNT_W'(1);
         PTR_AFTER_HIT: ptr_in = rdq_next;
         PTR_INC:       ptr_in = ptr_ff + CNT_W'(1);
         PTR_DEC:       ptr_in = ptr_ff - CNT_W'(1);
         default:       ptr_in = ptr_ff;
      endcase
   end

   // Write port selection: shift moves or the new key.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = rdq_ff;
      wr_data = rd_data_ff;
      case (cmd.wr_op)
         WR_UP:   wr_addr = rdq_ff + IDX_W'(1);
         WR_DOWN: wr_addr = rdq_ff - IDX_W'(1);
         WR_KEY: begin
            wr_addr = pos_idx;
            wr_data = key_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // Fill count update.
   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   // Reported index selection.
   always_comb begin
      case (cmd.idx_sel)
         IDX_RDQ:   rsp_idx_in = rdq_ff;
         IDX_SAVED: rsp_idx_in = idx_ff;
         default:   rsp_idx_in = '0;
      endcase
   end

   // Entry memory with one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= op_type'(req_func);
         key_ff  <= req_key;
         pos_ff  <= req_position;
      end
      if (rd_en) begin
         rdq_ff <= rd_addr;
      end
      if (cmd.save_idx) begin
         idx_ff <= rdq_ff;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_len_ff    <= count_in;
      end
      ptr_ff <= ptr_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_index  = 4'(rsp_idx_ff);
   assign rsp_length_after = 5'(rsp_len_ff);

   // The fill count never passes the table size.
   `UTSID_ASSERT(a_count_bound, count_ff <= CNT_W'(DEPTH), "fill count above table size")
   // Read data in flight always comes from a valid entry.
   `UTSID_ASSERT_IMPL(a_read_valid, rd_vld_ff, CNT_W'(rdq_ff) < count_ff, "read past fill count")
   // Each request yields a single one-cycle response.
   `UTSID_ASSERT_NEXT(a_one_strobe, rsp_valid_ff, !rsp_valid_ff, "response strobe repeated")

endmodule

// File: rtl/core/utsid_ctrl.sv
// Controller state machine of the unsorted table: sequences scans, shifts and responses.
// Depends on utsid_pkg.
module utsid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  utsid_pkg::flags_type  flags,
   output utsid_pkg::cmd_type    cmd,
   output logic                  busy
);
   import utsid_pkg::*;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (flags.func)
               OP_FIND, OP_DELETE: state_in = flags.empty ? S_IDLE : S_SCAN;
               OP_INSERT: begin
                  if (flags.full || flags.pos_bad) begin
                     state_in = S_IDLE;
                  end else if (flags.append) begin
                     state_in = S_INS_WRITE;
                  end else begin
                     state_in = S_INS_SHIFT;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            if (flags.hit) begin
               if (flags.func == OP_DELETE && !flags.last_up) begin
                  state_in = S_DEL_SHIFT;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (flags.rd_vld && flags.last_up) begin
               state_in = S_IDLE;
            end
         end
         S_DEL_SHIFT: begin
            if (flags.rd_vld && flags.last_up) begin
               state_in = S_IDLE;
            end
         end
         S_INS_SHIFT: begin
            if (flags.rd_vld && flags.last_ins) begin
               state_in = S_INS_WRITE;
            end
         end
         S_INS_WRITE: state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd            = '0;
      cmd.ptr_op     = PTR_HOLD;
      cmd.wr_op      = WR_NONE;
      cmd.cnt_op     = CNT_HOLD;
      cmd.rsp_status = ST_OK;
      cmd.idx_sel    = IDX_ZERO;
      case (state_ff)
         S_IDLE: cmd.capture = start;
         S_DECODE: begin
            case (flags.func)
               OP_FIND, OP_DELETE: begin
                  if (flags.empty) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_NOT_FOUND;
                  end else begin
                     cmd.ptr_op = PTR_ZERO;
                  end
               end
               OP_INSERT: begin
                  if (flags.full) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else if (flags.pos_bad) begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = ST_BAD_POS;
                  end else if (!flags.append) begin
                     cmd.ptr_op = PTR_TOP;
                  end
               end
               default: cmd.respond = 1'b1;
            endcase
         end
         S_SCAN: begin
            cmd.ptr_op = PTR_INC;
            if (flags.hit) begin
               if (flags.func == OP_DELETE && !flags.last_up) begin
                  cmd.save_idx = 1'b1;
                  cmd.ptr_op   = PTR_AFTER_HIT;
               end else begin
                  cmd.respond = 1'b1;
                  cmd.idx_sel = IDX_RDQ;
                  if (flags.func == OP_DELETE) begin
                     cmd.cnt_op = CNT_DEC;
                  end
               end
            end else if (flags.rd_vld && flags.last_up) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
            end else begin
               cmd.rd = 1'b1;
            end
         end
         S_DEL_SHIFT: begin
            cmd.ptr_op = PTR_INC;
            cmd.rd     = 1'b1;
            if (flags.rd_vld) begin
               cmd.wr_op = WR_DOWN;
               if (flags.last_up) begin
                  cmd.rd      = 1'b0;
                  cmd.cnt_op  = CNT_DEC;
                  cmd.respond = 1'b1;
                  cmd.idx_sel = IDX_SAVED;
               end
            end
         end
         S_INS_SHIFT: begin
            cmd.ptr_op = PTR_DEC;
            cmd.rd     = 1'b1;
            if (flags.rd_vld) begin
               cmd.wr_op = WR_UP;
               if (flags.last_ins) begin
                  cmd.rd = 1'b0;
               end
            end
         end
         S_INS_WRITE: begin
            cmd.wr_op   = WR_KEY;
            cmd.cnt_op  = CNT_INC;
            cmd.respond = 1'b1;
         end
         default: cmd.capture = 1'b0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// File: rtl/core/unsorted_table_search_insert_delete_top.sv
// Top level of the unsorted table with find, insert and delete commands.
// Depends on utsid_pkg, utsid_ctrl and utsid_dpath.
//
//   Channel   Ports                                         Handshake
//   request   req_func, req_key, req_position               start while busy is low
//   response  rsp_status, rsp_found_index, rsp_length_after rsp_strobe, one cycle
//
// One request at a time; one read and one write port with a registered read move one
// entry per cycle. A find or delete on an empty table, an insert into a full table or at a
// bad position, and the reserved code are answered straight from the decode state. The
// slowest case is a delete near the front of a full table; a new request is taken in the
// strobe cycle. Reset clears the fill count synchronously. Responses cannot be stalled.
module unsorted_table_search_insert_delete_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_key,
   input  logic [4:0]         req_position,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_found_index,
   output logic [4:0]         rsp_length_after
);
   import utsid_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   // Sequencer.
   utsid_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Table storage and response path.
   utsid_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found_index  (rsp_found_index),
      .rsp_length_after (rsp_length_after)
   );

endmodule

// File: bench/tb_unsorted_table_search_insert_delete_top.sv
// Self-checking testbench for the unsorted table top level: find, insert and delete requests.
// Depends on utsid_pkg and unsorted_table_search_insert_delete_top; it predicts each response
// from its own copy of the table, or takes it from a directed row, and compares it with the DUT.
module tb_unsorted_table_search_insert_delete_top;
   import utsid_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_REQUESTS = 1000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      status_type status;
      logic [3:0] index;
      logic [4:0] length;
   } table_result_type;

   typedef struct {
      op_type           func;
      logic [31:0]      key;
      logic [4:0]       position;
      bit               typed;
      table_result_type result;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_func;
   logic signed [31:0] req_key;
   logic [4:0]         req_position;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_found_index;
   logic [4:0]         rsp_length_after;

   // Model of the table as seen after every accepted request.
   logic [31:0]      tbl_entries [TABLE_DEPTH];
   int               tbl_count;
   table_result_type pending_results[$];
   int               requests_taken;
   int               error_count;
   bit               quiet_stretch;
   bit               typed_next;
   table_result_type typed_result;

   unsorted_table_search_insert_delete_top #(
      .DEPTH(TABLE_DEPTH)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_position     (req_position),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found_index  (rsp_found_index),
      .rsp_length_after (rsp_length_after)
   );

   // Free-running clock with a period of 10.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one request to the table model and returns the response it should give.
   function automatic table_result_type apply_table_command(op_type f, logic [31:0] k,
                                                            logic [4:0] p);
      table_result_type r;
      int hit;
      int i;
      r.status = ST_OK;
      r.index  = 4'd0;
      hit = -1;
      for (i = 0; i < tbl_count; i++) begin
         if (hit < 0 && tbl_entries[i] == k) hit = i;
      end
      case (f)
         OP_FIND: begin
            if (hit >= 0) r.index = hit[3:0];
            else r.status = ST_NOT_FOUND;
         end
         OP_INSERT: begin
            // A full table is reported before a bad position.
            if (tbl_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else if (p == 5'd0 || int'(p) > tbl_count + 1) begin
               r.status = ST_BAD_POS;
            end else begin
               for (i = tbl_count; i > int'(p) - 1; i--) tbl_entries[i] = tbl_entries[i - 1];
               tbl_entries[int'(p) - 1] = k;
               tbl_count++;
            end
         end
         OP_DELETE: begin
            // Only entries below the count move left; a miss leaves the count alone.
            if (hit >= 0) begin
               r.index = hit[3:0];
               for (i = hit; i + 1 < tbl_count; i++) tbl_entries[i] = tbl_entries[i + 1];
               tbl_count--;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
      r.length = tbl_count[4:0];
      return r;
   endfunction

   // Response checking first, then prediction of a request taken at the same edge.
   always @(posedge clock) begin
      table_result_type got;
      table_result_type want;
      table_result_type predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            got.status = status_type'(rsp_status);
            got.index  = rsp_found_index;
            got.length = rsp_length_after;
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("Response with no request pending: status %0d index %0d length %0d",
                           got.status, got.index, got.length);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS)
                     $display("Mismatch: status %0d/%0d index %0d/%0d length %0d/%0d (exp/got)",
                              want.status, got.status, want.index, got.index,
                              want.length, got.length);
               end
            end
         end
         if (start && !busy) begin
            predicted = apply_table_command(op_type'(req_func), req_key, req_position);
            pending_results.push_back(typed_next ? typed_result : predicted);
            requests_taken++;
         end
      end
   end

   // Presents one request after an optional random gap and holds it until it is taken.
   task automatic send_request(input op_type f, input logic [31:0] k, input logic [4:0] p,
                               input bit typed, input table_result_type exp);
      int target;
      if (!quiet_stretch && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
      end
      target = requests_taken + 1;
      typed_next = typed;
      typed_result = exp;
      start <= 1'b1;
      req_func <= f;
      req_key <= k;
      req_position <= p;
      do @(negedge clock); while (requests_taken < target);
   endtask

   // Stops sending and waits until every predicted response has arrived.
   task automatic wait_for_responses();
      start <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // Picks a key that is often already in the table, so finds and deletes hit.
   function automatic logic [31:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (tbl_count > 0 && roll < 55) return tbl_entries[$urandom_range(0, tbl_count - 1)];
      if (roll < 70) return 32'($urandom_range(0, 7));
      return $urandom;
   endfunction

   // Mostly legal insert positions, sometimes any 5-bit value.
   function automatic logic [4:0] pick_position();
      if ($urandom_range(0, 99) < 80) return 5'($urandom_range(1, tbl_count + 1));
      return 5'($urandom_range(0, 31));
   endfunction

   // Stimulus: directed table, a fill to full, then random requests in grow and shrink phases.
   initial begin
      directed_row_type directed_rows[20];
      table_result_type no_result;
      op_type           f;
      int               roll;
      bit               growing;
      logic [31:0]      last_key;

      reset = 1'b1;
      start = 1'b0;
      req_func = OP_FIND;
      req_key = '0;
      req_position = '0;
      tbl_count = 0;
      requests_taken = 0;
      error_count = 0;
      quiet_stretch = 1'b0;
      typed_next = 1'b0;
      no_result = '0;
      typed_result = '0;

      directed_rows = '{
         '{OP_FIND,   32'd0,          5'd0,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0}},
         '{OP_DELETE, 32'd5,          5'd0,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0}},
         '{OP_INSERT, 32'd7,          5'd0,  1'b1, '{ST_BAD_POS,   4'd0, 5'd0}},
         '{OP_INSERT, 32'd7,          5'd2,  1'b1, '{ST_BAD_POS,   4'd0, 5'd0}},
         '{OP_INSERT, 32'h8000_0000,  5'd1,  1'b1, '{ST_OK,        4'd0, 5'd1}},
         '{OP_INSERT, 32'h7FFF_FFFF,  5'd2,  1'b1, '{ST_OK,        4'd0, 5'd2}},
         '{OP_INSERT, 32'hFFFF_FFFF,  5'd1,  1'b1, '{ST_OK,        4'd0, 5'd3}},
         '{OP_INSERT, 32'd0,          5'd2,  1'b1, '{ST_OK,        4'd0, 5'd4}},
         '{OP_FIND,   32'h7FFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_FIND,   32'hFFFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_INSERT, 32'hFFFF_FFFF,  5'd5,  1'b1, '{ST_OK,        4'd0, 5'd5}},
         '{OP_FIND,   32'hFFFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_DELETE, 32'hFFFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_FIND,   32'hFFFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_RSVD,   32'h7FFF_FFFF,  5'd31, 1'b1, '{ST_OK,        4'd0, 5'd4}},
         '{OP_INSERT, 32'd9,          5'd31, 1'b1, '{ST_BAD_POS,   4'd0, 5'd4}},
         '{OP_INSERT, 32'd9,          5'd6,  1'b1, '{ST_BAD_POS,   4'd0, 5'd4}},
         '{OP_DELETE, 32'h7FFF_FFFF,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}},
         '{OP_DELETE, 32'd12345,      5'd0,  1'b1, '{ST_NOT_FOUND, 4'd0, 5'd3}},
         '{OP_FIND,   32'h8000_0000,  5'd0,  1'b0, '{ST_OK,        4'd0, 5'd0}}
      };

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed rows: empty table, bad positions, extreme keys, duplicates, reserved code.
      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].key, directed_rows[i].position,
                      directed_rows[i].typed, directed_rows[i].result);
      wait_for_responses();

      // Fill the table, insert into a full table, then find and remove the last entry.
      while (tbl_count < TABLE_DEPTH)
         send_request(OP_INSERT, $urandom, pick_position() == 5'd0 ? 5'd1 : 5'd1 +
                      5'($urandom_range(0, tbl_count)), 1'b0, no_result);
      send_request(OP_INSERT, $urandom, 5'($urandom_range(0, 31)), 1'b0, no_result);
      last_key = tbl_entries[TABLE_DEPTH - 1];
      send_request(OP_FIND, last_key, 5'd0, 1'b0, no_result);
      send_request(OP_DELETE, last_key, 5'd0, 1'b0, no_result);

      // Random requests; the table drifts up and down so full and empty both recur.
      growing = 1'b1;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0) growing = ~growing;
         quiet_stretch = (n >= 300 && n < 500);
         if (n == 600) wait_for_responses();
         roll = $urandom_range(0, 99);
         if (roll < 25) f = OP_FIND;
         else if (roll < (growing ? 70 : 40)) f = OP_INSERT;
         else if (roll < 95) f = OP_DELETE;
         else f = OP_RSVD;
         send_request(f, pick_key(), f == OP_INSERT ? pick_position() : 5'($urandom_range(0, 31)),
                      1'b0, no_result);
      end

      // Drain, then allow for a response that should not come.
      wait_for_responses();
      repeat (TABLE_DEPTH + 10) @(negedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: many times the slowest legal run.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/utsid_pkg.sv
rtl/core/utsid_dpath.sv
rtl/core/utsid_ctrl.sv
rtl/core/unsorted_table_search_insert_delete_top.sv
bench/tb_unsorted_table_search_insert_delete_top.sv
